// ===== sv/siph_pkg.sv =====
// ----------------------------------------------------------------------------
// siph_pkg: shared types, constants and round functions for SipHash-2-4
// Lane state type, initial vector constants, register indexes and the
// SipRound / compression functions used by the absorb and finalize stages.
// ----------------------------------------------------------------------------
package siph_pkg;

  localparam logic [63:0] IV_ZERO   = 64'h736f6d6570736575;
  localparam logic [63:0] IV_ONE    = 64'h646f72616e646f6d;
  localparam logic [63:0] IV_TWO    = 64'h6c7967656e657261;
  localparam logic [63:0] IV_THREE  = 64'h7465646279746573;
  localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned LEN_W     = 8;
  localparam logic [LEN_W-1:0] WORD_BYTES = 8'd8;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] v2;
    logic [WORD_W-1:0] v3;
  } lanes_t;

  // hand-off from the absorb stage to the finalize pipeline
  typedef struct packed {
    lanes_t            lanes;
    logic [WORD_W-1:0] tail;
  } fin_req_t;

  function automatic logic [WORD_W-1:0] rotl(logic [WORD_W-1:0] x, int unsigned r);
    return (x << r) | (x >> (WORD_W - r));
  endfunction

  function automatic lanes_t sip_round(lanes_t s);
    lanes_t t;
    t    = s;
    t.v0 = t.v0 + t.v1;
    t.v1 = rotl(t.v1, 13);
    t.v1 = t.v1 ^ t.v0;
    t.v0 = rotl(t.v0, 32);
    t.v2 = t.v2 + t.v3;
    t.v3 = rotl(t.v3, 16);
    t.v3 = t.v3 ^ t.v2;
    t.v0 = t.v0 + t.v3;
    t.v3 = rotl(t.v3, 21);
    t.v3 = t.v3 ^ t.v0;
    t.v2 = t.v2 + t.v1;
    t.v1 = rotl(t.v1, 17);
    t.v1 = t.v1 ^ t.v2;
    t.v2 = rotl(t.v2, 32);
    return t;
  endfunction

  function automatic lanes_t sip_double(lanes_t s);
    return sip_round(sip_round(s));
  endfunction

  // one message block: xor into v3, two rounds, xor into v0
  function automatic lanes_t sip_compress(lanes_t s, logic [WORD_W-1:0] m);
    lanes_t t;
    t    = s;
    t.v3 = t.v3 ^ m;
    t    = sip_double(t);
    t.v0 = t.v0 ^ m;
    return t;
  endfunction

endpackage

// ===== sv/siph_if.sv =====
// ----------------------------------------------------------------------------
// siph_if: stream channel interfaces for the SipHash block
// Message word channel and hash result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface siph_msg_if;
  import siph_pkg::*;
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  data_word;
  logic [COUNT_W-1:0] valid_bytes;
  logic               last;

  modport source (output valid, output data_word, output valid_bytes, output last,
                  input ready);
  modport sink   (input valid, input data_word, input valid_bytes, input last,
                  output ready);
endinterface

interface siph_hash_if;
  import siph_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] hash;

  modport source (output valid, output hash, input ready);
  modport sink   (input valid, input hash, output ready);
endinterface

// ===== sv/siph_absorb.sv =====
// ----------------------------------------------------------------------------
// siph_absorb: key registers, lane state and per-word compression
// Holds the running lanes and byte count; compresses each full word in the
// transfer cycle and hands the lanes plus the tail block to finalization.
// ----------------------------------------------------------------------------
module siph_absorb (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [siph_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [siph_pkg::WORD_W-1:0]        cfg_data,
  siph_msg_if.sink                           msg,
  output siph_pkg::fin_req_t                 fin,
  output logic                               fin_valid,
  input  logic                               fin_ready
);
  import siph_pkg::*;

  logic [WORD_W-1:0] key_low;
  logic [WORD_W-1:0] key_high;
  lanes_t            lanes;
  logic [LEN_W-1:0]  length_mod_256;
  logic              in_message;

  lanes_t             lanes_start;
  lanes_t             lanes_next;
  logic [LEN_W-1:0]   length_start;
  logic [LEN_W-1:0]   length_next;
  logic               full_word;
  logic               take;
  logic [WORD_W-1:0]  tail_data;

  assign msg.ready = fin_ready;
  assign take      = msg.valid & msg.ready;
  assign fin_valid = msg.valid & msg.last;

  // count of 8 or more on a last item means a full word
  assign full_word = ~msg.last | msg.valid_bytes[COUNT_W-1];

  always_comb begin
    if (in_message) begin
      lanes_start  = lanes;
      length_start = length_mod_256;
    end else begin
      lanes_start.v0 = IV_ZERO  ^ key_low;
      lanes_start.v1 = IV_ONE   ^ key_high;
      lanes_start.v2 = IV_TWO   ^ key_low;
      lanes_start.v3 = IV_THREE ^ key_high;
      length_start   = '0;
    end
  end

  always_comb begin
    if (full_word) begin
      lanes_next  = sip_compress(lanes_start, msg.data_word);
      length_next = length_start + WORD_BYTES;
    end else begin
      lanes_next  = lanes_start;
      length_next = length_start + {{(LEN_W-COUNT_W){1'b0}}, msg.valid_bytes};
    end
  end

  // keep only the valid low bytes of a short last word
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      if (!full_word && (COUNT_W'(b) < msg.valid_bytes))
        tail_data[8*b +: 8] = msg.data_word[8*b +: 8];
      else
        tail_data[8*b +: 8] = 8'h00;
    end
  end

  assign fin.lanes = lanes_next;
  assign fin.tail  = {length_next, tail_data[WORD_W-LEN_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low  <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_message <= 1'b0;
    end else if (take) begin
      in_message <= ~msg.last;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      lanes          <= lanes_next;
      length_mod_256 <= length_next;
    end
  end

  a_last_ends_msg: assert property (@(posedge clk) disable iff (rst)
    take && msg.last |=> !in_message)
    else $error("message still open after last transfer");

  a_first_word_len: assert property (@(posedge clk) disable iff (rst)
    take && !msg.last && !in_message |=> in_message && length_mod_256 == WORD_BYTES)
    else $error("byte count wrong after first word");

endmodule

// ===== sv/siph_final.sv =====
// ----------------------------------------------------------------------------
// siph_final: finalization pipeline and result register
// Three stages of two SipRounds each (tail block, then four final rounds),
// followed by the hash output register.
// ----------------------------------------------------------------------------
module siph_final (
  input  logic                 clk,
  input  logic                 rst,
  input  siph_pkg::fin_req_t   fin,
  input  logic                 fin_valid,
  output logic                 fin_ready,
  siph_hash_if.source          digest
);
  import siph_pkg::*;

  logic              s1_valid;
  lanes_t            s1_lanes;
  logic [WORD_W-1:0] s1_tail;
  logic              s2_valid;
  lanes_t            s2_lanes;
  logic              s3_valid;
  lanes_t            s3_lanes;
  logic              hash_valid;
  logic [WORD_W-1:0] hash;

  lanes_t            s1_res;
  lanes_t            s2_res;
  lanes_t            s3_res;
  logic [WORD_W-1:0] s3_hash;
  logic              out_free;
  logic              s3_free;
  logic              s2_free;
  logic              s1_free;

  assign out_free  = ~hash_valid | digest.ready;
  assign s3_free   = ~s3_valid | out_free;
  assign s2_free   = ~s2_valid | s3_free;
  assign s1_free   = ~s1_valid | s2_free;
  assign fin_ready = s1_free;

  always_comb begin
    s1_res    = sip_compress(s1_lanes, s1_tail);
    s1_res.v2 = s1_res.v2 ^ FINAL_XOR;
    s2_res    = sip_double(s2_lanes);
    s3_res    = sip_double(s3_lanes);
    s3_hash   = s3_res.v0 ^ s3_res.v1 ^ s3_res.v2 ^ s3_res.v3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      hash_valid <= 1'b0;
    end else begin
      if (s1_free)  s1_valid   <= fin_valid;
      if (s2_free)  s2_valid   <= s1_valid;
      if (s3_free)  s3_valid   <= s2_valid;
      if (out_free) hash_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && fin_valid) begin
      s1_lanes <= fin.lanes;
      s1_tail  <= fin.tail;
    end
    if (s2_free && s1_valid) s2_lanes <= s1_res;
    if (s3_free && s2_valid) s3_lanes <= s2_res;
    if (out_free && s3_valid) hash <= s3_hash;
  end

  assign digest.valid = hash_valid;
  assign digest.hash  = hash;

  a_fin_loads_s1: assert property (@(posedge clk) disable iff (rst)
    fin_valid && fin_ready |=> s1_valid)
    else $error("finalize request lost at stage one");

  a_out_from_s3: assert property (@(posedge clk) disable iff (rst)
    $rose(hash_valid) |-> $past(s3_valid))
    else $error("hash shown without a stage three item");

endmodule

// ===== sv/siphash_2_4_stream.sv =====
// ----------------------------------------------------------------------------
// siphash_2_4_stream: keyed SipHash-2-4 over a stream of 64-bit words
// Load the 128-bit key with two config writes (index 0 = key_low, index 1 =
// key_high) while idle; keys are sampled when a message starts. Feed the
// message as little-endian 64-bit words on msg, one transfer per cycle; the
// final transfer sets last and carries 0 to 8 valid low bytes (counts of 9..15
// act as 8, and valid_bytes is ignored on non-last words). Each word is
// compressed with two SipRounds in the cycle of its transfer, so the lane
// update loop sets the rate at one word per clock while msg.ready is high. A
// last word enters a three-stage finalization pipeline (tail block, then four
// final rounds) and passes through stages s1, s2, s3 and the hash output
// register before digest.valid rises. The pipeline and the output register
// let up to four finished messages queue behind a stalled digest sink before
// msg.ready drops.
// ----------------------------------------------------------------------------
module siphash_2_4_stream (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [siph_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [siph_pkg::WORD_W-1:0]    cfg_data,
  siph_msg_if.sink                       msg,
  siph_hash_if.source                    digest
);
  import siph_pkg::*;

  // absorb -> finalize hand-off: lanes after the last full word plus the
  // tail block with the byte count in its top byte
  fin_req_t fin;
  logic     fin_valid;
  logic     fin_ready;

  siph_absorb u_absorb (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .msg       (msg),
    .fin       (fin),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready)
  );

  // finalization rounds and the result register for digest transfers
  siph_final u_final (
    .clk       (clk),
    .rst       (rst),
    .fin       (fin),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .digest    (digest)
  );

endmodule
